/* hw/rtl/fcgird_pkg.sv */
`default_nettype none

package fcgird_pkg;

  // Depth of the queue between the parser and the result stage.
  localparam int QueueDepthDefault = 4;

  // Record type codes from the record header.
  localparam logic [7:0] TypeBeginRequest = 8'd1;
  localparam logic [7:0] TypeEndRequest   = 8'd3;
  localparam logic [7:0] TypeStreamFirst  = 8'd4;
  localparam logic [7:0] TypeStreamLast   = 8'd8;

  localparam logic [2:0] HeaderLastIndex = 3'd7;
  localparam int         BodyBytes       = 8;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_CONTENT = 2'd1,
    PH_PADDING = 2'd2
  } phase_t;

  // Result kind as seen on the result port.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_BODY    = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_t;

  // One queued result in compact form. For a content byte, value holds
  // {payload byte, offset, zero}; for a decoded body it holds body bytes 0..4.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  record_type;
    logic [15:0] request_id;
    logic [15:0] content_length;
    logic [39:0] value;
    logic        last;
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/fcgird_front.sv */
`default_nettype none

module fcgird_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        data_byte,
  output fcgird_pkg::cmd_t       cmd,
  output logic                   cmd_valid
);

  fcgird_pkg::phase_t phase, phase_next;
  logic [2:0]  header_count, header_count_next;
  logic [63:0] header_store, header_store_next;
  logic [63:0] body_store, body_store_next;
  logic [15:0] content_position, content_position_next;
  logic [7:0]  padding_left, padding_left_next;

  logic [63:0] header_shift;
  logic [63:0] body_upd;
  logic [16:0] pos_inc;
  logic        fin;
  logic [7:0]  cur_type;
  logic [15:0] cur_len;
  logic [7:0]  new_type;
  logic [15:0] new_len;
  logic [7:0]  new_pad;
  logic        known;
  logic        is_stream;
  logic        is_fixed;
  logic [7:0]  pad_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= fcgird_pkg::PH_HEADER;
      header_count     <= '0;
      header_store     <= '0;
      body_store       <= '0;
      content_position <= '0;
      padding_left     <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      header_count     <= header_count_next;
      header_store     <= header_store_next;
      body_store       <= body_store_next;
      content_position <= content_position_next;
      padding_left     <= padding_left_next;
    end
  end

  always_comb begin
    header_shift = {header_store[55:0], data_byte};
    cur_type     = header_store[55:48];
    cur_len      = header_store[31:16];
    new_type     = header_shift[55:48];
    new_len      = header_shift[31:16];
    new_pad      = header_shift[15:8];
    known        = (new_type != 8'd0) && (new_type <= fcgird_pkg::TypeStreamLast);
    is_stream    = (cur_type >= fcgird_pkg::TypeStreamFirst) &&
                   (cur_type <= fcgird_pkg::TypeStreamLast);
    is_fixed     = (cur_type == fcgird_pkg::TypeBeginRequest) ||
                   (cur_type == fcgird_pkg::TypeEndRequest);
    pos_inc      = {1'b0, content_position} + 17'd1;
    fin          = pos_inc >= {1'b0, cur_len};
    pad_dec      = (padding_left != 8'd0) ? padding_left - 8'd1 : 8'd0;
    body_upd     = body_store;
    if (content_position < 16'(fcgird_pkg::BodyBytes)) begin
      body_upd = body_store |
                 ({56'd0, data_byte} << (6'd56 - {content_position[2:0], 3'b000}));
    end

    phase_next            = phase;
    header_count_next     = header_count;
    header_store_next     = header_store;
    body_store_next       = body_store;
    content_position_next = content_position;
    padding_left_next     = padding_left;

    cmd.kind           = fcgird_pkg::KIND_HEADER;
    cmd.record_type    = cur_type;
    cmd.request_id     = header_store[47:32];
    cmd.content_length = cur_len;
    cmd.value          = '0;
    cmd.last           = 1'b0;
    cmd_valid          = 1'b0;

    case (phase)
      fcgird_pkg::PH_CONTENT: begin
        content_position_next = pos_inc[15:0];
        if (is_fixed) begin
          body_store_next = body_upd;
        end
        if (is_stream) begin
          cmd_valid = 1'b1;
          cmd.kind  = fcgird_pkg::KIND_CONTENT;
          cmd.value = {data_byte, content_position, 16'd0};
          cmd.last  = fin;
        end else if (is_fixed && fin) begin
          cmd_valid = 1'b1;
          cmd.kind  = fcgird_pkg::KIND_BODY;
          cmd.value = body_upd[63:24];
          cmd.last  = 1'b1;
        end
        if (fin) begin
          phase_next = (padding_left != 8'd0) ? fcgird_pkg::PH_PADDING
                                               : fcgird_pkg::PH_HEADER;
        end
      end
      fcgird_pkg::PH_PADDING: begin
        padding_left_next = pad_dec;
        if (pad_dec == 8'd0) begin
          phase_next = fcgird_pkg::PH_HEADER;
        end
      end
      default: begin
        // Header phase; the unused phase code behaves the same way.
        header_store_next = header_shift;
        if (header_count >= fcgird_pkg::HeaderLastIndex) begin
          header_count_next     = '0;
          body_store_next       = '0;
          content_position_next = '0;
          padding_left_next     = new_pad;
          cmd_valid             = 1'b1;
          cmd.kind              = known ? fcgird_pkg::KIND_HEADER : fcgird_pkg::KIND_UNKNOWN;
          cmd.record_type       = new_type;
          cmd.request_id        = header_shift[47:32];
          cmd.content_length    = new_len;
          cmd.last              = known && (new_len == 16'd0);
          if (new_len != 16'd0) begin
            phase_next = fcgird_pkg::PH_CONTENT;
          end else begin
            phase_next = (new_pad != 8'd0) ? fcgird_pkg::PH_PADDING
                                            : fcgird_pkg::PH_HEADER;
          end
        end else begin
          header_count_next = header_count + 3'd1;
          phase_next        = fcgird_pkg::PH_HEADER;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/fcgird_queue.sv */
`default_nettype none

module fcgird_queue #(
  parameter int Depth = fcgird_pkg::QueueDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire fcgird_pkg::cmd_t wr_data,
  input  wire logic             rd_en,
  output fcgird_pkg::cmd_t      rd_data,
  output logic                  is_full,
  output logic                  is_empty
);

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  fcgird_pkg::cmd_t  mem [Depth];
  logic [AddrW-1:0]  wr_ptr;
  logic [AddrW-1:0]  rd_ptr;
  logic [CountW-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign is_full  = (count == CountW'(Depth));
  assign is_empty = (count == '0);
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && !is_empty;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CountW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CountW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fcgird_back.sv */
`default_nettype none

module fcgird_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fcgird_pkg::cmd_t q_data,
  input  wire logic             q_empty,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  empty,
  output logic [1:0]            kind,
  output logic [7:0]            record_type,
  output logic [15:0]           request_id,
  output logic [15:0]           content_length,
  output logic [7:0]            payload_byte,
  output logic [15:0]           byte_offset,
  output logic [15:0]           role,
  output logic [7:0]            flags,
  output logic [31:0]           app_status,
  output logic [7:0]            protocol_status,
  output logic                  last
);

  fcgird_pkg::cmd_t held;
  logic             held_valid;
  logic             is_begin;
  logic             is_end;

  assign q_pop = !q_empty && (!held_valid || pop);
  assign empty = !held_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (q_pop) begin
      held_valid <= 1'b1;
    end else if (pop) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      held <= q_data;
    end
  end

  always_comb begin
    kind            = held.kind;
    record_type     = held.record_type;
    request_id      = held.request_id;
    content_length  = held.content_length;
    last            = held.last;
    payload_byte    = '0;
    byte_offset     = '0;
    role            = '0;
    flags           = '0;
    app_status      = '0;
    protocol_status = '0;
    is_begin        = held.record_type == fcgird_pkg::TypeBeginRequest;
    is_end          = held.record_type == fcgird_pkg::TypeEndRequest;
    case (held.kind)
      fcgird_pkg::KIND_CONTENT: begin
        payload_byte = held.value[39:32];
        byte_offset  = held.value[31:16];
      end
      fcgird_pkg::KIND_BODY: begin
        if (is_begin) begin
          role  = held.value[39:24];
          flags = held.value[23:16];
        end else if (is_end) begin
          app_status      = held.value[39:8];
          protocol_status = held.value[7:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/fastcgi_record_deframer_unit.sv */
`default_nettype none

// Channel   Handshake             Payload
// input     push / full           data_byte
// results   empty / pop           kind, record_type, request_id, content_length,
//                                 payload_byte, byte_offset, role, flags,
//                                 app_status, protocol_status, last
//
// The parser takes one byte per cycle while the queue is not full; every
// byte updates its state in the cycle it is accepted, and a byte that yields
// a result writes it into a short queue. The result passes from the queue
// into the output register, which holds it until popped. Sustained rate
// is one byte per cycle as long as results are popped as fast as they are made.
// Reset is synchronous and returns the parser to the start of a record
// header with the queue and the output register empty. full rises only when
// the queue is full; a stalled output register holds its result while the
// parser keeps working into the queue.

module fastcgi_record_deframer_unit #(
  parameter int QueueDepth = fcgird_pkg::QueueDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       record_type,
  output logic [15:0]      request_id,
  output logic [15:0]      content_length,
  output logic [7:0]       payload_byte,
  output logic [15:0]      byte_offset,
  output logic [15:0]      role,
  output logic [7:0]       flags,
  output logic [31:0]      app_status,
  output logic [7:0]       protocol_status,
  output logic             last
);

  fcgird_pkg::cmd_t front_cmd;
  fcgird_pkg::cmd_t q_data;
  logic             front_valid;
  logic             accept;
  logic             q_empty;
  logic             q_pop;

  // A byte is taken whenever the queue has room, whether it yields a result
  // or not.
  assign accept = push && !full;

  fcgird_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .cmd       (front_cmd),
    .cmd_valid (front_valid)
  );

  fcgird_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && front_valid),
    .wr_data  (front_cmd),
    .rd_en    (q_pop),
    .rd_data  (q_data),
    .is_full  (full),
    .is_empty (q_empty)
  );

  // The result stage expands the compact queue entry into the output fields,
  // zeroing those that do not belong to the result's kind.
  fcgird_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_data          (q_data),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .kind            (kind),
    .record_type     (record_type),
    .request_id      (request_id),
    .content_length  (content_length),
    .payload_byte    (payload_byte),
    .byte_offset     (byte_offset),
    .role            (role),
    .flags           (flags),
    .app_status      (app_status),
    .protocol_status (protocol_status),
    .last            (last)
  );

endmodule

`default_nettype wire
